// File: rtl/tmbv_pkg.sv
package tmbv_pkg;

	localparam int unsigned ADC_W  = 12;
	localparam int unsigned MV_W   = 16;
	localparam int unsigned PROD_W = ADC_W + MV_W;

	typedef logic [ADC_W-1:0]  adc_t;
	typedef logic [MV_W-1:0]   mv_t;
	typedef logic [PROD_W-1:0] prod_t;

	localparam adc_t ADC_FULL_CODE    = 12'd4095;
	localparam mv_t  FULL_SCALE_RESET = 16'd9900;

	// Load enables of the scaling stages
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} scale_ld_t;

	// Exact floor(p / 4095): p = a*4096 + b = a*4095 + (a + b), then fold once more.
	function automatic mv_t div_full_code(input prod_t p);
		logic [MV_W:0]    fold;
		logic [4:0]       carry;
		logic [ADC_W:0]   rest;
		logic             adj;
		fold  = {1'b0, p[PROD_W-1:ADC_W]} + {5'b0, p[ADC_W-1:0]};
		carry = fold[MV_W:ADC_W];
		rest  = {8'b0, carry} + {1'b0, fold[ADC_W-1:0]};
		adj   = (rest >= {1'b0, ADC_FULL_CODE});
		return p[PROD_W-1:ADC_W] + mv_t'(carry) + mv_t'(adj);
	endfunction

endpackage

// File: rtl/tmbv_scale.sv
module tmbv_scale import tmbv_pkg::*; (
	input  logic      clk,
	input  adc_t      adc_sample,
	input  mv_t       full_scale,
	input  scale_ld_t ld,
	output mv_t       scaled_s3
);

	adc_t  sample_s1;
	prod_t prod_s2;

	// Capture, multiply, then divide by the full ADC code
	always_ff @(posedge clk) begin
		if (ld.s1) begin
			sample_s1 <= adc_sample;
		end
		if (ld.s2) begin
			prod_s2 <= prod_t'(sample_s1) * prod_t'(full_scale);
		end
		if (ld.s3) begin
			scaled_s3 <= div_full_code(prod_s2);
		end
	end

endmodule

// File: rtl/tmbv_trim.sv
module tmbv_trim import tmbv_pkg::*; #(
	parameter  int unsigned DEPTH = 4,
	localparam int unsigned SUM_W = MV_W + $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  mv_t              scaled,
	output logic [SUM_W-1:0] trim_sum_s4
);

	localparam int unsigned SLOT_W = $clog2(DEPTH);
	localparam int unsigned LVL    = $clog2(DEPTH);
	localparam int unsigned PAD    = 1 << LVL;

	mv_t               ring_q [DEPTH];
	logic [SLOT_W-1:0] slot_q;

	mv_t               hi_t  [LVL+1][PAD];
	mv_t               lo_t  [LVL+1][PAD];
	logic [SUM_W-1:0]  sum_t [LVL+1][PAD];
	logic [SUM_W-1:0]  trim_sum;

	// Ring as it stands once the new value is in, reduced by a max/min/sum tree
	always_comb begin
		hi_t  = '{default: '{default: '0}};
		lo_t  = '{default: '{default: '0}};
		sum_t = '{default: '{default: '0}};
		for (int j = 0; j < DEPTH; j++) begin
			hi_t[0][j]  = (slot_q == SLOT_W'(j)) ? scaled : ring_q[j];
			lo_t[0][j]  = hi_t[0][j];
			sum_t[0][j] = SUM_W'(hi_t[0][j]);
		end
		for (int j = DEPTH; j < PAD; j++) begin
			hi_t[0][j]  = '0;
			lo_t[0][j]  = '1;
			sum_t[0][j] = '0;
		end
		for (int l = 0; l < LVL; l++) begin
			for (int j = 0; j < (PAD >> (l + 1)); j++) begin
				hi_t[l+1][j]  = (hi_t[l][2*j] > hi_t[l][2*j+1]) ? hi_t[l][2*j] : hi_t[l][2*j+1];
				lo_t[l+1][j]  = (lo_t[l][2*j] < lo_t[l][2*j+1]) ? lo_t[l][2*j] : lo_t[l][2*j+1];
				sum_t[l+1][j] = sum_t[l][2*j] + sum_t[l][2*j+1];
			end
		end
		trim_sum = sum_t[LVL][0] - SUM_W'(hi_t[LVL][0]) - SUM_W'(lo_t[LVL][0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < DEPTH; j++) begin
				ring_q[j] <= '0;
			end
			slot_q <= '0;
		end else if (load) begin
			ring_q[slot_q] <= scaled;
			slot_q         <= (slot_q == SLOT_W'(DEPTH - 1)) ? '0 : slot_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			trim_sum_s4 <= trim_sum;
		end
	end

endmodule

// File: rtl/trimmed_mean_battery_voltage.sv
// Five register stages: capture, multiply, divide by 4095, ring update with trimmed sum, mean.
// Throughput: one beat per cycle unless a stalled output has filled all five stages; the stall chain sets the pace.
// Reset (arst_n low, asynchronous): all stages empty, ring entries zero, write slot zero,
// full scale 9900 mV. No clearing pass; the block takes beats right after reset.
module trimmed_mean_battery_voltage import tmbv_pkg::*; #(
	parameter int unsigned DEPTH = 4
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  cfg_wr_en,
	input  mv_t   cfg_wr_data,
	input  logic  adc_valid,
	output logic  adc_stall,
	input  adc_t  adc_sample,
	output logic  mv_valid,
	input  logic  mv_stall,
	output mv_t   battery_mv
);

	localparam int unsigned SUM_W   = MV_W + $clog2(DEPTH);
	localparam int unsigned DIVISOR = DEPTH - 2;
	// Reciprocal for the exact divide by DEPTH-2 of any SUM_W-bit sum
	localparam int unsigned DIV_SH  = SUM_W + $clog2(DIVISOR);
	localparam int unsigned RECIP_W = SUM_W + 1;
	localparam int unsigned MUL_W   = SUM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << DIV_SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

	mv_t              full_scale_q;
	logic             vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic             free_s1, free_s2, free_s3, free_s4, free_s5;
	scale_ld_t        scale_ld;
	logic             load_s4, load_s5;
	mv_t              scaled_s3;
	logic [SUM_W-1:0] trim_sum_s4;
	logic [MUL_W-1:0] mean_prod;
	mv_t              mean_s5;

	// Full-scale register; the user must write it only while idle, the block itself does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_scale_q <= FULL_SCALE_RESET;
		end else if (cfg_wr_en) begin
			full_scale_q <= cfg_wr_data;
		end
	end

	// A stage can take a beat when it is empty or its beat moves on this cycle.
	// Bubbles fill while the output beat waits, so input keeps flowing.
	assign free_s5 = !vld_s5 || !mv_stall;
	assign free_s4 = !vld_s4 || free_s5;
	assign free_s3 = !vld_s3 || free_s4;
	assign free_s2 = !vld_s2 || free_s3;
	assign free_s1 = !vld_s1 || free_s2;

	assign adc_stall = !free_s1;

	assign scale_ld.s1 = adc_valid && free_s1;
	assign scale_ld.s2 = vld_s1 && free_s2;
	assign scale_ld.s3 = vld_s2 && free_s3;
	assign load_s4     = vld_s3 && free_s4;
	assign load_s5     = vld_s4 && free_s5;

	// Advance the valid bits; a free stage takes whatever its upstream holds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (free_s1) vld_s1 <= adc_valid;
			if (free_s2) vld_s2 <= vld_s1;
			if (free_s3) vld_s3 <= vld_s2;
			if (free_s4) vld_s4 <= vld_s3;
			if (free_s5) vld_s5 <= vld_s4;
		end
	end

	// Scale the raw code to battery millivolts
	tmbv_scale u_scale (
		.clk        (clk),
		.adc_sample (adc_sample),
		.full_scale (full_scale_q),
		.ld         (scale_ld),
		.scaled_s3  (scaled_s3)
	);

	// Write the ring and form sum minus largest and smallest entry
	tmbv_trim #(
		.DEPTH (DEPTH)
	) u_trim (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (load_s4),
		.scaled      (scaled_s3),
		.trim_sum_s4 (trim_sum_s4)
	);

	// Divide by DEPTH-2 through the reciprocal; exact for every sum that fits SUM_W
	assign mean_prod = MUL_W'(trim_sum_s4) * MUL_W'(RECIP);

	always_ff @(posedge clk) begin
		if (load_s5) begin
			mean_s5 <= mean_prod[DIV_SH +: MV_W];
		end
	end

	assign mv_valid   = vld_s5;
	assign battery_mv = mean_s5;

endmodule

// File: rtl/tmbv_checker.sv
module tmbv_checker import tmbv_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic adc_valid,
	input logic adc_stall,
	input logic mv_valid,
	input logic mv_stall,
	input mv_t  battery_mv
);

	localparam logic [2:0] STAGES = 3'd5;

	logic [2:0] inflight_q;
	logic       acc_in, acc_out;

	assign acc_in  = adc_valid && !adc_stall;
	assign acc_out = mv_valid && !mv_stall;

	// Track beats accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + 3'(acc_in) - 3'(acc_out);
		end
	end

	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		mv_valid && mv_stall |=> mv_valid && $stable(battery_mv))
		else $error("result beat changed while stalled");

	a_empty_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		$past(!arst_n) |-> !mv_valid)
		else $error("result beat right after reset");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		mv_valid |-> inflight_q != 3'd0)
		else $error("result beat without an accepted input beat");

	a_full_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(inflight_q == STAGES) && mv_stall |-> adc_stall)
		else $error("input accepted with every stage full");

	a_empty_takes: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q == 3'd0 |-> !adc_stall)
		else $error("input stalled with nothing in flight");

endmodule

bind trimmed_mean_battery_voltage tmbv_checker u_tmbv_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.adc_valid  (adc_valid),
	.adc_stall  (adc_stall),
	.mv_valid   (mv_valid),
	.mv_stall   (mv_stall),
	.battery_mv (battery_mv)
);

// File: verif/battery_mv_checker.sv
module battery_mv_checker import tmbv_pkg::*; #(
	parameter int unsigned DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wr_en,
	input  mv_t  cfg_wr_data,
	input  logic adc_valid,
	input  logic adc_stall,
	input  adc_t adc_sample,
	input  logic mv_valid,
	input  logic mv_stall,
	input  mv_t  battery_mv,
	output int   mismatches,
	output int   awaited,
	output int   means_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	mv_t         mv_history [DEPTH];
	int unsigned next_slot;
	mv_t         full_scale;
	mv_t         expected_means [$];
	mv_t         want;

	initial begin
		mismatches    = 0;
		awaited       = 0;
		means_checked = 0;
	end

	// floor(code * full_scale / 4095), exact
	function automatic mv_t scale_to_mv(input adc_t code, input mv_t fs);
		prod_t product;
		product = prod_t'(code) * prod_t'(fs);
		return mv_t'(product / prod_t'(ADC_FULL_CODE));
	endfunction

	// Drop one largest and one smallest entry, average the rest
	function automatic mv_t trim_mean(input mv_t ring [DEPTH]);
		logic [31:0] total;
		mv_t         top_v;
		mv_t         bottom_v;
		total    = '0;
		top_v    = '0;
		bottom_v = '1;
		foreach (ring[i]) begin
			if (ring[i] > top_v)
				top_v = ring[i];
			if (ring[i] < bottom_v)
				bottom_v = ring[i];
			total += 32'(ring[i]);
		end
		total = total - 32'(top_v) - 32'(bottom_v);
		return mv_t'(total / (DEPTH - 2));
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (mv_history[i])
				mv_history[i] = '0;
			next_slot  = 0;
			full_scale = FULL_SCALE_RESET;
			expected_means.delete();
		end else begin
			if (adc_valid && !adc_stall) begin
				mv_history[next_slot] = scale_to_mv(adc_sample, full_scale);
				next_slot = (next_slot + 1) % DEPTH;
				expected_means.push_back(trim_mean(mv_history));
			end
			if (mv_valid && !mv_stall) begin
				if (expected_means.size() == 0) begin
					mismatches++;
					$display("%0t: battery_mv beat with nothing expected, actual %0d",
						$time, battery_mv);
				end else begin
					want = expected_means.pop_front();
					means_checked++;
					if (battery_mv !== want) begin
						mismatches++;
						$display("%0t: battery_mv mismatch, expected %0d actual %0d",
							$time, want, battery_mv);
					end
				end
			end
			if (cfg_wr_en)
				full_scale = cfg_wr_data;
		end
		awaited = expected_means.size();
	end

endmodule

// File: verif/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import tmbv_pkg::*;

	localparam int unsigned DEPTH       = 4;
	localparam int          SEG_ITEMS   = 275;
	localparam int          SETTLE_CYC  = 8;

	logic clk         = 1'b0;
	logic arst_n      = 1'b0;
	logic cfg_wr_en   = 1'b0;
	mv_t  cfg_wr_data = '0;
	logic adc_valid   = 1'b0;
	logic adc_stall;
	adc_t adc_sample  = '0;
	logic mv_valid;
	logic mv_stall    = 1'b0;
	mv_t  battery_mv;

	int mismatch_total;
	int awaited_total;
	int means_checked;

	// Flow-control mix: percent of cycles the source idles / the sink stalls
	int send_idle_pct  = 11;
	int recv_stall_pct = 49;
	int samples_sent   = 0;
	int settings_used  = 1;

	always #1 clk = ~clk;

	trimmed_mean_battery_voltage #(.DEPTH(DEPTH)) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.adc_valid   (adc_valid),
		.adc_stall   (adc_stall),
		.adc_sample  (adc_sample),
		.mv_valid    (mv_valid),
		.mv_stall    (mv_stall),
		.battery_mv  (battery_mv)
	);

	battery_mv_checker #(.DEPTH(DEPTH)) checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.adc_valid     (adc_valid),
		.adc_stall     (adc_stall),
		.adc_sample    (adc_sample),
		.mv_valid      (mv_valid),
		.mv_stall      (mv_stall),
		.battery_mv    (battery_mv),
		.mismatches    (mismatch_total),
		.awaited       (awaited_total),
		.means_checked (means_checked)
	);

	// Sink side: stall at random, one decision per falling edge
	always @(negedge clk) begin
		mv_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Offer one sample beat; hold it until the block takes it at a rising edge.
	// Valid stays high on return so back-to-back beats never drop it.
	task automatic send_sample(input adc_t code);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			adc_valid  <= 1'b0;
			adc_sample <= adc_t'($urandom);
			@(negedge clk);
		end
		adc_valid  <= 1'b1;
		adc_sample <= code;
		@(posedge clk);
		while (adc_stall)
			@(posedge clk);
		samples_sent++;
	endtask

	// Drop valid and wait until every mean has come back
	task automatic drain_means();
		@(negedge clk);
		adc_valid <= 1'b0;
		while (awaited_total != 0)
			@(negedge clk);
		repeat (SETTLE_CYC) @(negedge clk);
	endtask

	// Retune the full scale only while the pipeline is empty
	task automatic set_full_scale(input mv_t value);
		drain_means();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
		settings_used++;
	endtask

	// Mix of rail codes, repeats for ties, small steps and uniform noise
	function automatic adc_t pick_sample(input adc_t last_code);
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 12)
			return '0;
		else if (roll < 24)
			return ADC_FULL_CODE;
		else if (roll < 40)
			return last_code;
		else if (roll < 52)
			return last_code + adc_t'($urandom_range(8)) - adc_t'(4);
		else
			return adc_t'($urandom);
	endfunction

	initial begin : stimulus
		adc_t directed_codes [$];
		adc_t last_code;
		mv_t  seg_scale [6];

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// Directed: reset scale, ring starts at zero, rails, ties, mid codes
		directed_codes = '{12'd0, 12'd4095, 12'd4095, 12'd4095, 12'd4095,
			12'd1, 12'd2048, 12'd2048, 12'd4094, 12'd0};
		foreach (directed_codes[i])
			send_sample(directed_codes[i]);

		// Zero full scale: every scaled value collapses to zero
		set_full_scale(16'd0);
		send_sample(12'd4095);
		send_sample(12'd1234);
		send_sample(12'd4095);
		send_sample(12'd0);

		// Largest full scale with the largest code: scaled value hits 65535
		set_full_scale(16'hFFFF);
		repeat (4) send_sample(12'd4095);
		send_sample(12'd0);
		send_sample(12'd4095);

		// Random segments: two scale settings per flow-control mix
		seg_scale = '{16'hFFFF, 16'd1, mv_t'($urandom), FULL_SCALE_RESET,
			16'd3300, mv_t'($urandom)};
		last_code = '0;
		for (int seg = 0; seg < 6; seg++) begin
			case (seg / 2)
				0: begin
					send_idle_pct  = 11;
					recv_stall_pct = 49;
				end
				1: begin
					send_idle_pct  = 49;
					recv_stall_pct = 11;
				end
				default: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
			endcase
			set_full_scale(seg_scale[seg]);
			for (int n = 0; n < SEG_ITEMS; n++) begin
				last_code = pick_sample(last_code);
				send_sample(last_code);
			end
		end

		drain_means();
		$display("tb_top: %0d samples sent, %0d trimmed means checked", samples_sent,
			means_checked);
		$display("tb_top: %0d full-scale settings, three source/sink flow mixes",
			settings_used);
		if (mismatch_total == 0 && awaited_total == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run
	initial begin
		#2000000;
		$display("tb_top: FAIL");
		$finish;
	end

endmodule
